/* hw/rtl/weighted_share_selector_top_macros.svh */
// ---------------------------------------------------------------------------
// weighted_share_selector_top_macros.svh
// Assertion macros shared by the weighted share selector modules.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_SHARE_SELECTOR_TOP_MACROS_SVH
`define WEIGHTED_SHARE_SELECTOR_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define WSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wss_pkg.sv */
// ---------------------------------------------------------------------------
// wss_pkg
// Shared widths, codes and controller/datapath interface types for the
// weighted share selector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wss_pkg;

    // Default configuration of the share table
    localparam int DEF_NUM_BEHAVIORS = 16;
    localparam int DEF_INITIAL_SHARE = 100;
    localparam int DEF_SHARE_BITS    = 16;

    // Field widths of the transfer payloads
    localparam int KIND_W  = 1;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 4;
    localparam int CONS_W  = 16;
    localparam int DRAWN_W = 20;
    localparam int ENTRY_W = 16;
    localparam int TOTAL_W = 20;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_CHOOSE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_ADJUST = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // latch a new item and clear the working registers
        logic div_step;    // one restoring step of the modulo
        logic rd_scan;     // read the table entry under the scan pointer
        logic rd_adj;      // read the table entry to be adjusted
        logic scan_check;  // accumulate and compare the entry just read
        logic adj_write;   // write the clipped share and correct the total
        logic out_load;    // load the output register
    } t_wss_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_adjust;   // offered item is an adjust
        logic in_range;    // latched entry index lies inside the table
        logic div_last;    // current modulo step is the last one
        logic scan_hit;    // scan has found its entry
    } t_wss_sts;

endpackage

/* hw/rtl/weighted_share_selector_top.sv */
// ---------------------------------------------------------------------------
// weighted_share_selector_top
// Roulette wheel selection over a table of share counts with signed
// share adjustment and a running total.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: kind 0 draws
//   a behavior from i_random_word, kind 1 adds i_consequence to the entry
//   i_entry_index. Output channel (o_out_valid / i_out_stall) returns one
//   result per item, in order.
//   One item is worked at a time. A choose runs a bit-serial modulo of
//   the random word against the running total, then reads and checks
//   each table entry visited by the scan (single-port table with
//   registered read) until the draw falls inside an entry or the last
//   entry is reached. An adjust reads the entry and writes it back, or
//   skips both when the index lies outside the table.
//   A finished result sits in the output register while the next item is
//   accepted and worked; the block waits before loading another result
//   only while that register is still stalled.
//   Reset (synchronous) sets every share to the initial share and the
//   total to the table size times it, with no clearing pass, and empties
//   the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_share_selector_top
    import wss_pkg::*;
#(
    parameter int NUM_BEHAVIORS = DEF_NUM_BEHAVIORS,
    parameter int INITIAL_SHARE = DEF_INITIAL_SHARE,
    parameter int SHARE_BITS    = DEF_SHARE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic [WORD_W-1:0]         i_random_word,
    input  logic [INDEX_W-1:0]        i_entry_index,
    input  logic signed [CONS_W-1:0]  i_consequence,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [INDEX_W-1:0]        o_chosen_index,
    output logic [DRAWN_W-1:0]        o_drawn_share,
    output logic [ENTRY_W-1:0]        o_entry_shares,
    output logic [TOTAL_W-1:0]        o_total_shares,
    output logic                      o_saturated
);

    t_wss_cmd cmd;
    t_wss_sts sts;

    // Sequencer
    wss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Table, total, modulo and scan
    wss_datapath #(
        .NUM_BEHAVIORS (NUM_BEHAVIORS),
        .INITIAL_SHARE (INITIAL_SHARE),
        .SHARE_BITS    (SHARE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_random_word  (i_random_word),
        .i_entry_index  (i_entry_index),
        .i_consequence  (i_consequence),
        .o_chosen_index (o_chosen_index),
        .o_drawn_share  (o_drawn_share),
        .o_entry_shares (o_entry_shares),
        .o_total_shares (o_total_shares),
        .o_saturated    (o_saturated)
    );

endmodule

/* hw/rtl/wss_datapath.sv */
// ---------------------------------------------------------------------------
// wss_datapath
// Share table, running total, serial modulo unit, cumulative scan and
// clipped adjust, with the output payload register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weighted_share_selector_top_macros.svh"

module wss_datapath
    import wss_pkg::*;
#(
    parameter int NUM_BEHAVIORS = DEF_NUM_BEHAVIORS,
    parameter int INITIAL_SHARE = DEF_INITIAL_SHARE,
    parameter int SHARE_BITS    = DEF_SHARE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_wss_cmd                  i_cmd,
    output t_wss_sts                  o_sts,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic [WORD_W-1:0]         i_random_word,
    input  logic [INDEX_W-1:0]        i_entry_index,
    input  logic signed [CONS_W-1:0]  i_consequence,
    output logic [INDEX_W-1:0]        o_chosen_index,
    output logic [DRAWN_W-1:0]        o_drawn_share,
    output logic [ENTRY_W-1:0]        o_entry_shares,
    output logic [TOTAL_W-1:0]        o_total_shares,
    output logic                      o_saturated
);

    localparam int SW     = SHARE_BITS;
    localparam int IDX_W  = $clog2(NUM_BEHAVIORS);
    localparam int TOT_W  = SW + IDX_W;
    localparam int ADJ_W  = ((SW > CONS_W) ? SW : CONS_W) + 2;
    localparam int CNT_W  = $clog2(WORD_W);
    localparam logic [63:0]       MAX64    = (64'd1 << SW) - 64'd1;
    localparam logic [SW-1:0]     SHARE_MAX = SW'(MAX64);
    localparam logic [SW-1:0]     INIT_SH  =
        (64'(INITIAL_SHARE) > MAX64) ? SHARE_MAX : SW'(INITIAL_SHARE);
    localparam logic [TOT_W-1:0]  INIT_TOT =
        TOT_W'(64'(NUM_BEHAVIORS) * 64'(INIT_SH));
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BEHAVIORS - 1);
    localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(WORD_W - 1);

    // Latched item
    logic [KIND_W-1:0]        r_kind;
    logic [WORD_W-1:0]        r_word;
    logic [INDEX_W-1:0]       r_idx;
    logic signed [CONS_W-1:0] r_cons;

    // Working state
    logic [TOT_W-1:0]  r_total;
    logic [TOT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div_cnt;
    logic [IDX_W-1:0]  r_scan_idx;
    logic [TOT_W-1:0]  r_cum;
    logic [IDX_W-1:0]  r_pick;
    logic [SW-1:0]     r_entry;
    logic              r_sat;

    // Share table with per-entry valid bits
    logic [SW-1:0]            r_mem [NUM_BEHAVIORS];
    logic [NUM_BEHAVIORS-1:0] r_valid;
    logic [SW-1:0]            r_rd_data;

    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         adj_addr;
    logic [TOT_W:0]           shifted;
    logic                     rem_ge;
    logic [TOT_W-1:0]         n_rem;
    logic [TOT_W-1:0]         drawn;
    logic [TOT_W-1:0]         cum_next;
    logic signed [ADJ_W-1:0]  adj_sum;
    logic                     adj_floor;
    logic                     adj_ceil;
    logic [SW-1:0]            adj_new;
    logic [TOT_W:0]           tot_sum;

    assign adj_addr = IDX_W'(r_idx);
    assign rd_addr  = i_cmd.rd_adj ? adj_addr : r_scan_idx;

    // Restoring modulo step: shift in the next word bit, subtract if it fits
    assign shifted = {r_rem, r_word[WORD_W-1]};
    assign rem_ge  = (shifted >= {1'b0, r_total});
    assign n_rem   = rem_ge ? TOT_W'(shifted - {1'b0, r_total}) : TOT_W'(shifted);
    assign drawn   = (r_total == '0) ? '0 : r_rem;

    // Cumulative scan compare
    assign cum_next = r_cum + TOT_W'(r_rd_data);

    // Adjust: signed add, floor at one, ceiling at the share maximum
    assign adj_sum   = signed'(ADJ_W'(r_rd_data)) + ADJ_W'(r_cons);
    assign adj_floor = adj_sum[ADJ_W-1] || (adj_sum == '0);
    assign adj_ceil  = !adj_sum[ADJ_W-1] && (unsigned'(adj_sum) > ADJ_W'(SHARE_MAX));
    always_comb begin
        if (adj_floor) begin
            adj_new = SW'(1);
        end else if (adj_ceil) begin
            adj_new = SHARE_MAX;
        end else begin
            adj_new = SW'(adj_sum);
        end
    end
    assign tot_sum = (TOT_W + 1)'(r_total) + (TOT_W + 1)'(adj_new)
                   - (TOT_W + 1)'(r_rd_data);

    // Status back to the controller
    assign o_sts.in_adjust = (i_kind == KIND_ADJUST);
    assign o_sts.in_range  = (32'(r_idx) < 32'(NUM_BEHAVIORS));
    assign o_sts.div_last  = (r_div_cnt == LAST_CNT);
    assign o_sts.scan_hit  = (cum_next > drawn) || (r_scan_idx == LAST_IDX);

    // Latch the item and run the modulo
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_word    <= i_random_word;
            r_idx     <= i_entry_index;
            r_cons    <= i_consequence;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_word    <= {r_word[WORD_W-2:0], 1'b0};
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
    end

    // Scan pointer, cumulative sum and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scan_idx <= '0;
            r_cum      <= '0;
            r_pick     <= '0;
            r_entry    <= '0;
            r_sat      <= 1'b0;
        end else if (i_cmd.scan_check) begin
            r_cum <= cum_next;
            if (o_sts.scan_hit) begin
                r_pick  <= r_scan_idx;
                r_entry <= r_rd_data;
            end else begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
        end else if (i_cmd.adj_write) begin
            r_entry <= adj_new;
            r_sat   <= adj_ceil;
        end
    end

    // Running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= INIT_TOT;
        end else if (i_cmd.adj_write) begin
            r_total <= TOT_W'(tot_sum);
        end
    end

    // Table valid bits: an entry not yet written reads as the initial share
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.adj_write) begin
            r_valid[adj_addr] <= 1'b1;
        end
    end

    // Table write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.adj_write) begin
            r_mem[adj_addr] <= adj_new;
        end
    end

    // Table read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_scan || i_cmd.rd_adj) begin
            r_rd_data <= r_valid[rd_addr] ? r_mem[rd_addr] : INIT_SH;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_kind == KIND_ADJUST) begin
                o_chosen_index <= r_idx;
                o_drawn_share  <= '0;
            end else begin
                o_chosen_index <= INDEX_W'(r_pick);
                o_drawn_share  <= DRAWN_W'(drawn);
            end
            o_entry_shares <= ENTRY_W'(r_entry);
            o_total_shares <= TOTAL_W'(r_total);
            o_saturated    <= r_sat;
        end
    end

    `WSS_ASSERT_SAME(a_total_floor, i_clk, i_rst_n, 1'b1, r_total >= TOT_W'(NUM_BEHAVIORS), "running total fell below one share per entry")
    `WSS_ASSERT_SAME(a_adj_nonzero, i_clk, i_rst_n, i_cmd.adj_write, adj_new != '0, "adjust would write a zero share")
    `WSS_ASSERT_SAME(a_rem_below_total, i_clk, i_rst_n, i_cmd.scan_check, (r_rem < r_total) || (r_total == '0), "modulo remainder not below the total")

endmodule

/* hw/rtl/wss_ctrl.sv */
// ---------------------------------------------------------------------------
// wss_ctrl
// Sequencer for the weighted share selector: handshakes, modulo steps,
// table scan, adjust and output register ownership.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weighted_share_selector_top_macros.svh"

module wss_ctrl
    import wss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_wss_sts i_sts,
    output t_wss_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DIV      = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CHK = 7'b0001000,
        S_ADJ_RD   = 7'b0010000,
        S_ADJ_WR   = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_xfer;
    logic   out_free;

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_adjust ? S_ADJ_RD : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.scan_check = 1'b1;
                n_state          = i_sts.scan_hit ? S_FIN : S_SCAN_RD;
            end
            S_ADJ_RD: begin
                if (i_sts.in_range) begin
                    o_cmd.rd_adj = 1'b1;
                    n_state      = S_ADJ_WR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ADJ_WR: begin
                o_cmd.adj_write = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes the transfer
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `WSS_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || !i_out_stall, "output register overwritten while stalled")
    `WSS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_xfer, (r_state == S_DIV) || (r_state == S_ADJ_RD), "accepted item did not start work")
    `WSS_ASSERT_SAME(a_check_after_read, i_clk, i_rst_n, r_state == S_SCAN_CHK, $past(r_state) == S_SCAN_RD, "scan compare without a preceding table read")

endmodule

/* tb/weighted_share_selector_top_test.sv */
// ---------------------------------------------------------------------------
// weighted_share_selector_top_test
// Self-checking bench for the roulette wheel share selector. A clocked
// driver feeds choose and adjust transfers from a queue of pending items.
// A clocked monitor predicts each accepted item against its own copy of the
// share table and running total, and compares every result transfer in
// order. Both sides idle at random. The receiver also holds off for a long
// stretch, and the sender pauses twice until the block has drained.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_share_selector_top_test
    import wss_pkg::*;
();

    localparam int NUM_ENTRIES  = DEF_NUM_BEHAVIORS;
    localparam int SHARE_MAX    = (1 << DEF_SHARE_BITS) - 1;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic [WORD_W-1:0]         word;
        logic [INDEX_W-1:0]        idx;
        logic signed [CONS_W-1:0]  cons;
        bit                        steady;       // no idle cycle before this one
        bit                        drain_first;  // wait for all results first
    } t_share_item;

    typedef struct {
        logic [INDEX_W-1:0]  chosen;
        logic [DRAWN_W-1:0]  drawn;
        logic [ENTRY_W-1:0]  entry;
        logic [TOTAL_W-1:0]  total;
        logic                sat;
    } t_share_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [KIND_W-1:0]         i_kind = KIND_CHOOSE;
    logic [WORD_W-1:0]         i_random_word = '0;
    logic [INDEX_W-1:0]        i_entry_index = '0;
    logic signed [CONS_W-1:0]  i_consequence = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [INDEX_W-1:0]        o_chosen_index;
    logic [DRAWN_W-1:0]        o_drawn_share;
    logic [ENTRY_W-1:0]        o_entry_shares;
    logic [TOTAL_W-1:0]        o_total_shares;
    logic                      o_saturated;

    // Shadow copy of the share table and its running total
    logic [ENTRY_W-1:0]  share_tbl_m [NUM_ENTRIES];
    logic [20:0]         total_m;

    t_share_item    share_items_q [$];
    t_share_result  share_expect_q [$];

    int accept_cnt = 0;
    int result_cnt = 0;
    int error_cnt  = 0;
    int cycle_cnt  = 0;
    int built_cnt  = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    weighted_share_selector_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_random_word  (i_random_word),
        .i_entry_index  (i_entry_index),
        .i_consequence  (i_consequence),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_chosen_index (o_chosen_index),
        .o_drawn_share  (o_drawn_share),
        .o_entry_shares (o_entry_shares),
        .o_total_shares (o_total_shares),
        .o_saturated    (o_saturated)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Return the shadow table to its reset contents
    task automatic reset_share_table();
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            share_tbl_m[i] = ENTRY_W'(DEF_INITIAL_SHARE);
        end
        total_m = 21'(NUM_ENTRIES * DEF_INITIAL_SHARE);
    endtask

    // Apply one item to the shadow table and return its result
    function automatic t_share_result predict_share_step(input t_share_item it);
        t_share_result r;
        logic [31:0]   drawn_full;
        logic [20:0]   cum;
        bit            found;
        int            nv;
        logic [15:0]   old_share;
        logic [15:0]   new_share;
        r.chosen = '0;
        r.drawn  = '0;
        r.entry  = '0;
        r.sat    = 1'b0;
        if (it.kind == KIND_CHOOSE) begin
            drawn_full = (total_m != 0) ? it.word % {11'd0, total_m} : 32'd0;
            r.drawn    = drawn_full[DRAWN_W-1:0];
            r.chosen   = INDEX_W'(NUM_ENTRIES - 1);
            cum        = '0;
            found      = 1'b0;
            // Walk the cumulative shares until the draw falls inside one
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (!found) begin
                    cum = cum + share_tbl_m[i];
                    if ({11'd0, cum} > drawn_full) begin
                        r.chosen = INDEX_W'(i);
                        found    = 1'b1;
                    end
                end
            end
            r.entry = share_tbl_m[r.chosen];
        end else begin
            r.chosen = it.idx;
            if (int'(it.idx) < NUM_ENTRIES) begin
                old_share = share_tbl_m[it.idx];
                nv = int'(old_share) + int'(it.cons);
                // Floor at one, clip at the share maximum
                if (nv <= 0) begin
                    new_share = 16'd1;
                end else if (nv > SHARE_MAX) begin
                    new_share = 16'(SHARE_MAX);
                    r.sat     = 1'b1;
                end else begin
                    new_share = 16'(nv);
                end
                share_tbl_m[it.idx] = new_share;
                total_m = total_m - old_share + new_share;
                r.entry = new_share;
            end
        end
        r.total = total_m[TOTAL_W-1:0];
        return r;
    endfunction

    // Queue one item, marking the steady stretch and the drain points
    task automatic push_item(input logic [KIND_W-1:0] kind, input logic [31:0] word,
                             input logic [3:0] idx, input logic signed [15:0] cons);
        t_share_item it;
        it.kind        = kind;
        it.word        = word;
        it.idx         = idx;
        it.cons        = cons;
        it.steady      = (built_cnt >= 700 && built_cnt < 900);
        it.drain_first = (built_cnt == 400 || built_cnt == 1100);
        share_items_q.push_back(it);
        built_cnt++;
    endtask

    // Push every entry to the ceiling, or collapse every entry to one
    task automatic push_sweep(input logic signed [15:0] cons);
        for (int pass = 0; pass < 3; pass++) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                push_item(KIND_ADJUST, $urandom, 4'(e), cons);
            end
        end
    endtask

    // Driver: advance to the next pending item when the transfer completes
    always @(posedge i_clk) begin : drive_items
        t_share_item nxt;
        logic        took;
        took = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || took) begin
            if (share_items_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (share_items_q[0].drain_first &&
                         (took || accept_cnt != result_cnt)) begin
                i_in_valid <= 1'b0;
            end else if (!share_items_q[0].steady && $urandom_range(99) < 31) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = share_items_q.pop_front();
                i_in_valid    <= 1'b1;
                i_kind        <= nxt.kind;
                i_random_word <= nxt.word;
                i_entry_index <= nxt.idx;
                i_consequence <= nxt.cons;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, one stretch without stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && result_cnt >= 250) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else if (result_cnt >= 700 && result_cnt < 900) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 31);
        end
    end

    // Monitor: check result transfers, then predict accepted items
    always @(posedge i_clk) begin : watch_results
        t_share_result want;
        t_share_item   seen;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                result_cnt <= result_cnt + 1;
                if (share_expect_q.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS) begin
                        $display("unexpected result: idx %0d drawn %0d entry %0d total %0d",
                                 o_chosen_index, o_drawn_share, o_entry_shares,
                                 o_total_shares);
                    end
                end else begin
                    want = share_expect_q.pop_front();
                    if (o_chosen_index !== want.chosen || o_drawn_share !== want.drawn ||
                        o_entry_shares !== want.entry || o_total_shares !== want.total ||
                        o_saturated !== want.sat) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS) begin
                            $display({"result %0d expected idx %0d drawn %0d",
                                      " entry %0d total %0d sat %0b"},
                                     result_cnt, want.chosen, want.drawn, want.entry,
                                     want.total, want.sat);
                            $display({"result %0d actual   idx %0d drawn %0d",
                                      " entry %0d total %0d sat %0b"},
                                     result_cnt, o_chosen_index, o_drawn_share,
                                     o_entry_shares, o_total_shares, o_saturated);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                accept_cnt  <= accept_cnt + 1;
                seen.kind   = i_kind;
                seen.word   = i_random_word;
                seen.idx    = i_entry_index;
                seen.cons   = i_consequence;
                seen.steady = 1'b0;
                seen.drain_first = 1'b0;
                share_expect_q.push_back(predict_share_step(seen));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[weighted_share_selector_top] ERROR");
            $finish;
        end
    end

    // Stimulus and end of test
    initial begin : run_test
        int r;
        reset_share_table();

        // Directed: draw extremes, ceiling, floor, zero change
        push_item(KIND_CHOOSE, 32'd0, 4'd0, 16'sd0);
        push_item(KIND_CHOOSE, 32'hFFFF_FFFF, 4'd15, -16'sd1);
        push_item(KIND_CHOOSE, 32'd1599, 4'd0, 16'sd0);
        push_item(KIND_CHOOSE, 32'd1600, 4'd0, 16'sd0);
        push_item(KIND_CHOOSE, 32'h8000_0000, 4'd0, 16'sd0);
        push_item(KIND_ADJUST, 32'd0, 4'd0, 16'sh7FFF);
        push_item(KIND_ADJUST, 32'd0, 4'd0, 16'sh7FFF);
        push_item(KIND_CHOOSE, 32'd0, 4'd0, 16'sd0);
        push_item(KIND_ADJUST, 32'd0, 4'd15, -16'sh8000);
        push_item(KIND_ADJUST, 32'd0, 4'd15, 16'sd0);
        push_item(KIND_CHOOSE, 32'hFFFF_FFFF, 4'd0, 16'sd0);
        push_item(KIND_ADJUST, 32'hFFFF_FFFF, 4'd7, -16'sd1);
        push_item(KIND_ADJUST, 32'd0, 4'd3, 16'sd1);
        push_item(KIND_CHOOSE, 32'd65535, 4'd0, 16'sd0);
        push_item(KIND_ADJUST, 32'd0, 4'd0, -16'sh8000);
        push_item(KIND_ADJUST, 32'd0, 4'd0, -16'sh8000);
        push_item(KIND_CHOOSE, 32'd98, 4'd0, 16'sd0);
        push_item(KIND_CHOOSE, 32'd99, 4'd0, 16'sd0);

        // Random: mixed items with occasional sweeps to the table extremes
        while (built_cnt < 1450) begin
            if (built_cnt % 200 == 100) begin
                push_sweep(($urandom_range(1)) ? 16'sh7FFF : -16'sh8000);
            end
            r = $urandom_range(99);
            if (r < 38) begin
                push_item(KIND_CHOOSE, $urandom, 4'($urandom), 16'($urandom));
            end else if (r < 50) begin
                push_item(KIND_CHOOSE, ($urandom_range(1)) ? $urandom_range(4095)
                                                           : ~32'($urandom_range(4095)),
                          4'($urandom), 16'($urandom));
            end else if (r < 80) begin
                push_item(KIND_ADJUST, $urandom, 4'($urandom),
                          16'(int'($urandom_range(400)) - 200));
            end else if (r < 92) begin
                push_item(KIND_ADJUST, $urandom, 4'($urandom), 16'($urandom));
            end else begin
                push_item(KIND_ADJUST, $urandom, 4'($urandom),
                          ($urandom_range(1)) ? 16'sh7FFF : -16'sh8000);
            end
        end

        // Release reset once the queue of items is built
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to go in and every result to come back
        while (share_items_q.size() != 0 || i_in_valid || accept_cnt != result_cnt) begin
            @(negedge i_clk);
        end
        repeat (100) @(negedge i_clk);

        if (share_expect_q.size() != 0) begin
            $display("%0d results never arrived", share_expect_q.size());
        end
        if (error_cnt == 0 && share_expect_q.size() == 0) begin
            $display("[weighted_share_selector_top] OK");
        end else begin
            $display("[weighted_share_selector_top] ERROR");
        end
        $finish;
    end

endmodule

/* weighted_share_selector_top.f */
+incdir+hw/rtl
hw/rtl/wss_pkg.sv
hw/rtl/wss_datapath.sv
hw/rtl/wss_ctrl.sv
hw/rtl/weighted_share_selector_top.sv
tb/weighted_share_selector_top_test.sv
